/* design/sm4_pkg.sv */
// ----------------------------------------------------------------------------
// SM4 package
// Shared types, constants and round functions of the SM4 block cipher.
// ----------------------------------------------------------------------------
`default_nettype none

package sm4_pkg;

   localparam int ROUND_COUNT_DEFAULT = 32;
   localparam int KEY_WORDS = 4;
   localparam int CSR_INDEX_WIDTH = 2;

   localparam logic OP_ENCRYPT = 1'b0;
   localparam logic OP_DECRYPT = 1'b1;

   localparam logic [31:0] FK0 = 32'ha3b1bac6;
   localparam logic [31:0] FK1 = 32'h56aa3350;
   localparam logic [31:0] FK2 = 32'h677d9197;
   localparam logic [31:0] FK3 = 32'hb27022dc;

   typedef struct packed {
      logic        operation;
      logic [63:0] block_hi;
      logic [63:0] block_lo;
   } req_type;

   typedef struct packed {
      logic [63:0] result_hi;
      logic [63:0] result_lo;
   } rsp_type;

   typedef struct packed {
      logic load_key;
      logic key_round;
      logic load_data;
      logic data_round;
      logic decrypt;
   } cmd_type;

   function automatic logic [7:0] sbox(input logic [7:0] a);
      logic [7:0] tbl [256];
      tbl = '{
         8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
         8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
         8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
         8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
         8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
         8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
         8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
         8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
         8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
         8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
         8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
         8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
         8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
         8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
         8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
         8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48};
      return tbl[a];
   endfunction

   function automatic logic [31:0] tau(input logic [31:0] a);
      return {sbox(a[31:24]), sbox(a[23:16]), sbox(a[15:8]), sbox(a[7:0])};
   endfunction

   function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
      return (x << n) | (x >> (32 - n));
   endfunction

   function automatic logic [31:0] lin_data(input logic [31:0] b);
      return b ^ rotl(b, 2) ^ rotl(b, 10) ^ rotl(b, 18) ^ rotl(b, 24);
   endfunction

   function automatic logic [31:0] lin_key(input logic [31:0] b);
      return b ^ rotl(b, 13) ^ rotl(b, 23);
   endfunction

   function automatic logic [31:0] ck_word(input logic [4:0] i);
      logic [7:0] base;
      base = {1'b0, i, 2'b00};
      return {8'((base + 8'd0) * 8'd7), 8'((base + 8'd1) * 8'd7),
              8'((base + 8'd2) * 8'd7), 8'((base + 8'd3) * 8'd7)};
   endfunction

endpackage

`default_nettype wire

/* design/sm4_ctrl.sv */
// ----------------------------------------------------------------------------
// SM4 controller
// Sequences the key expansion rounds, then the data rounds, then the result.
// ----------------------------------------------------------------------------
`default_nettype none

module sm4_ctrl #(
   parameter int ROUND_COUNT = sm4_pkg::ROUND_COUNT_DEFAULT
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic             operation,
   output logic                  busy,
   output logic                  done,
   output sm4_pkg::cmd_type      cmd,
   output logic [$clog2(ROUND_COUNT)-1:0] round_index
);
   import sm4_pkg::*;

   localparam int IW = $clog2(ROUND_COUNT);
   localparam logic [IW-1:0] LAST = IW'(ROUND_COUNT - 1);

   typedef enum logic [1:0] {ST_IDLE, ST_KEY, ST_DATA, ST_DONE} state_type;

   state_type     state_ff;
   logic [IW-1:0] round_ff;
   logic          decrypt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         round_ff   <= '0;
         decrypt_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               round_ff <= '0;
               if (start) begin
                  decrypt_ff <= (operation == OP_DECRYPT);
                  state_ff   <= ST_KEY;
               end
            end
            ST_KEY: begin
               round_ff <= round_ff + 1'b1;
               if (round_ff == LAST) state_ff <= ST_DATA;
            end
            ST_DATA: begin
               round_ff <= round_ff + 1'b1;
               if (round_ff == LAST) state_ff <= ST_DONE;
            end
            ST_DONE: begin
               round_ff <= '0;
               state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign busy        = (state_ff != ST_IDLE);
   assign done        = (state_ff == ST_DONE);
   assign round_index = round_ff;

   always_comb begin
      cmd            = '0;
      cmd.load_key   = (state_ff == ST_IDLE) && start;
      cmd.load_data  = cmd.load_key;
      cmd.key_round  = (state_ff == ST_KEY);
      cmd.data_round = (state_ff == ST_DATA);
      cmd.decrypt    = decrypt_ff;
   end

endmodule

`default_nettype wire

/* design/sm4_dpath.sv */
// ----------------------------------------------------------------------------
// SM4 datapath
// Key registers, round key store, key round unit and data round unit.
// ----------------------------------------------------------------------------
`default_nettype none

module sm4_dpath #(
   parameter int ROUND_COUNT = sm4_pkg::ROUND_COUNT_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_valid,
   input  wire logic [sm4_pkg::CSR_INDEX_WIDTH:0] csr_index,
   input  wire logic [31:0]           csr_data,
   input  wire sm4_pkg::req_type      req,
   input  wire sm4_pkg::cmd_type      cmd,
   input  wire logic [$clog2(ROUND_COUNT)-1:0] round_index,
   output sm4_pkg::rsp_type           rsp
);
   import sm4_pkg::*;

   localparam int IW = $clog2(ROUND_COUNT);

   logic [31:0]   key_ff [KEY_WORDS];
   logic [31:0]   kw_ff  [4];
   logic [31:0]   xw_ff  [4];
   logic [31:0]   rk_mem [ROUND_COUNT];
   logic [31:0]   rk_rd_ff;
   logic [31:0]   key_new_in;
   logic [31:0]   data_new_in;
   logic [IW-1:0] rd_addr;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < KEY_WORDS; i++) key_ff[i] <= '0;
      end else if (csr_valid && !csr_index[CSR_INDEX_WIDTH]) begin
         key_ff[csr_index[CSR_INDEX_WIDTH-1:0]] <= csr_data;
      end
   end

   assign key_new_in = kw_ff[0] ^ lin_key(tau(kw_ff[1] ^ kw_ff[2] ^ kw_ff[3]
                                             ^ ck_word(5'(round_index))));

   always_ff @(posedge clock) begin
      if (cmd.load_key) begin
         kw_ff[0] <= key_ff[0] ^ FK0;
         kw_ff[1] <= key_ff[1] ^ FK1;
         kw_ff[2] <= key_ff[2] ^ FK2;
         kw_ff[3] <= key_ff[3] ^ FK3;
      end else if (cmd.key_round) begin
         kw_ff[0] <= kw_ff[1];
         kw_ff[1] <= kw_ff[2];
         kw_ff[2] <= kw_ff[3];
         kw_ff[3] <= key_new_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.key_round) rk_mem[round_index] <= key_new_in;
   end

   // The round key for the next data round is read ahead into a register.
   always_comb begin
      logic [IW-1:0] nxt;
      nxt = cmd.key_round ? '0 : round_index + 1'b1;
      rd_addr = cmd.decrypt ? IW'(ROUND_COUNT - 1) - nxt : nxt;
   end

   always_ff @(posedge clock) begin
      if (cmd.key_round && round_index == IW'(ROUND_COUNT - 1) && !cmd.decrypt)
         rk_rd_ff <= rk_mem[0];
      else if (cmd.key_round && round_index == IW'(ROUND_COUNT - 1))
         rk_rd_ff <= key_new_in;
      else
         rk_rd_ff <= rk_mem[rd_addr];
   end

   assign data_new_in = xw_ff[0] ^ lin_data(tau(xw_ff[1] ^ xw_ff[2] ^ xw_ff[3]
                                               ^ rk_rd_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 4; i++) xw_ff[i] <= '0;
      end else if (cmd.load_data) begin
         xw_ff[0] <= req.block_hi[63:32];
         xw_ff[1] <= req.block_hi[31:0];
         xw_ff[2] <= req.block_lo[63:32];
         xw_ff[3] <= req.block_lo[31:0];
      end else if (cmd.data_round) begin
         xw_ff[0] <= xw_ff[1];
         xw_ff[1] <= xw_ff[2];
         xw_ff[2] <= xw_ff[3];
         xw_ff[3] <= data_new_in;
      end
   end

   assign rsp.result_hi = {xw_ff[3], xw_ff[2]};
   assign rsp.result_lo = {xw_ff[1], xw_ff[0]};

endmodule

`default_nettype wire

/* design/sm4_block_cipher_top.sv */
// ----------------------------------------------------------------------------
// SM4 block cipher top level
// Encrypts or decrypts one 128-bit block with a 128-bit key held in registers.
//
// Channel   Ports                               Handshake
// request   start, busy, req_payload            taken when start high, busy low
// response  rsp_strobe, rsp_payload             one cycle, cannot be held off
// csr       csr_valid, csr_ready, csr_index,    taken when valid and ready
//           csr_data
//
// A result is shown after its item in order: the key round unit runs its
// rounds, then the data round unit runs its rounds, then the result is shown.
// The next item can be taken once busy has fallen after the result strobe.
// Reset is synchronous and active high; the round key store needs no clearing.
// Busy stays high through the result strobe; the receiver cannot stall.
// ----------------------------------------------------------------------------
`default_nettype none

module sm4_block_cipher_top #(
   parameter int ROUND_COUNT = sm4_pkg::ROUND_COUNT_DEFAULT
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   output logic                      busy,
   input  wire sm4_pkg::req_type     req_payload,
   output logic                      rsp_strobe,
   output sm4_pkg::rsp_type          rsp_payload,
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [sm4_pkg::CSR_INDEX_WIDTH:0] csr_index,
   input  wire logic [31:0]          csr_data
);
   import sm4_pkg::*;

   cmd_type                        cmd;
   logic [$clog2(ROUND_COUNT)-1:0] round_index;

   assign csr_ready = 1'b1;

   sm4_ctrl #(.ROUND_COUNT(ROUND_COUNT)) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .operation   (req_payload.operation),
      .busy        (busy),
      .done        (rsp_strobe),
      .cmd         (cmd),
      .round_index (round_index)
   );

   sm4_dpath #(.ROUND_COUNT(ROUND_COUNT)) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .csr_valid   (csr_valid),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .req         (req_payload),
      .cmd         (cmd),
      .round_index (round_index),
      .rsp         (rsp_payload)
   );

endmodule

`default_nettype wire

/* design/sm4_checker.sv */
// ----------------------------------------------------------------------------
// SM4 port checker
// Watches the top level's ports for handshake and sequencing slips.
// ----------------------------------------------------------------------------
`default_nettype none

module sm4_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic start,
   input wire logic busy,
   input wire logic rsp_strobe
);
   import sm4_pkg::*;

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy) else $error("Item taken but busy stayed low.");
   a_strobe_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe) else $error("Result strobe lasted too long.");
   a_strobe_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> busy) else $error("Result shown while idle.");
   a_release: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !busy) else $error("Busy held after the result.");

endmodule

bind sm4_block_cipher_top sm4_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_strobe (rsp_strobe)
);

`default_nettype wire
